FILE: rtl/core/srb_pkg.sv
// shared types, codes and defaults for the serial ring buffer block
package srb_pkg;

  localparam int FUNC_W       = 2;
  localparam int BYTE_W       = 8;
  localparam int CNT_W        = 8;
  localparam int RX_DEPTH_DEF = 32;
  localparam int TX_DEPTH_DEF = 32;

  // item function codes
  localparam logic [FUNC_W-1:0] FN_RX_BYTE  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LINE_RDY = 2'd1;
  localparam logic [FUNC_W-1:0] FN_ENQ      = 2'd2;
  localparam logic [FUNC_W-1:0] FN_READ     = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic cap;        // capture input item
    logic rx_push;    // store line byte in receive ring
    logic tx_direct;  // send enqueued byte straight to line
    logic tx_refuse;  // transmit ring full
    logic tx_push;    // queue transmit byte
    logic tx_fetch;   // read oldest queued transmit byte
    logic tx_send;    // hand fetched byte to line
    logic line_rel;   // nothing queued, line goes free
    logic rd_start;   // load read count, fetch first byte
    logic rd_send;    // deliver one received byte
    logic rd_none;    // empty read result
  } srb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              tx_empty;
    logic              tx_full;
    logic              line_free;
    logic              rd_zero;
    logic              rd_last;
    logic              slot_free;
  } srb_sts_t;

endpackage

FILE: rtl/core/srb_ctrl.sv
// controller state machine sequencing one item at a time
module srb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  srb_pkg::srb_sts_t sts,
  output srb_pkg::srb_cmd_t cmd
);
  import srb_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_TXOUT = 2'd2;
  localparam logic [1:0] S_RDOUT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.func)
          FN_RX_BYTE: begin
            if (sts.slot_free) begin
              cmd.rx_push = 1'b1;
              state_nxt   = S_IDLE;
            end
          end
          FN_LINE_RDY: begin
            if (!sts.tx_empty) begin
              cmd.tx_fetch = 1'b1;
              state_nxt    = S_TXOUT;
            end else if (sts.slot_free) begin
              cmd.line_rel = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          FN_ENQ: begin
            if (sts.slot_free) begin
              if (sts.tx_empty && sts.line_free) begin
                cmd.tx_direct = 1'b1;
              end else if (sts.tx_full) begin
                cmd.tx_refuse = 1'b1;
              end else begin
                cmd.tx_push = 1'b1;
              end
              state_nxt = S_IDLE;
            end
          end
          FN_READ: begin
            if (!sts.rd_zero) begin
              cmd.rd_start = 1'b1;
              state_nxt    = S_RDOUT;
            end else if (sts.slot_free) begin
              cmd.rd_none = 1'b1;
              state_nxt   = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_TXOUT: begin
        if (sts.slot_free) begin
          cmd.tx_send = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_RDOUT: begin
        if (sts.slot_free) begin
          cmd.rd_send = 1'b1;
          if (sts.rd_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/srb_dp.sv
// datapath: both rings, their pointers and the result register
module srb_dp #(
  parameter int RX_DEPTH = srb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = srb_pkg::TX_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [srb_pkg::FUNC_W-1:0]  in_func,
  input  logic [srb_pkg::BYTE_W-1:0]  in_byte,
  input  logic [srb_pkg::CNT_W-1:0]   in_read_count,
  input  srb_pkg::srb_cmd_t           cmd,
  output srb_pkg::srb_sts_t           sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_line_valid,
  output logic [srb_pkg::BYTE_W-1:0]  out_line_byte,
  output logic                        out_enq_accepted,
  output logic                        out_read_valid,
  output logic [srb_pkg::BYTE_W-1:0]  out_read_byte,
  output logic                        out_last
);
  import srb_pkg::*;

  localparam int RPW = $clog2(RX_DEPTH);
  localparam int TPW = $clog2(TX_DEPTH);
  localparam logic [RPW-1:0] RX_TOP = RPW'(RX_DEPTH - 1);
  localparam logic [TPW-1:0] TX_TOP = TPW'(TX_DEPTH - 1);
  localparam logic [RPW:0]   RX_SPAN = (RPW + 1)'(RX_DEPTH);

  // captured item
  logic [FUNC_W-1:0] func_r;
  logic [BYTE_W-1:0] byte_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [RPW-1:0] rx_wp_r, rx_rp_r, rem_r;
  logic [TPW-1:0] tx_wp_r, tx_rp_r;
  logic           line_free_r;

  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
  logic [BYTE_W-1:0] rx_q_r, tx_q_r;

  logic              out_valid_r;
  logic              out_lv_r, out_acc_r, out_rv_r, out_last_r;
  logic [BYTE_W-1:0] out_lb_r, out_rb_r;

  logic [RPW-1:0] rx_wp_inc, rx_rp_inc, rx_rd_addr, avail, n_rd;
  logic [TPW-1:0] tx_wp_inc, tx_rp_inc;
  logic [RPW:0]   diff;
  logic [CNT_W-1:0] avail_w, n_w;
  logic             emit, slot_free;

  assign rx_wp_inc = (rx_wp_r == RX_TOP) ? '0 : rx_wp_r + 1'b1;
  assign rx_rp_inc = (rx_rp_r == RX_TOP) ? '0 : rx_rp_r + 1'b1;
  assign tx_wp_inc = (tx_wp_r == TX_TOP) ? '0 : tx_wp_r + 1'b1;
  assign tx_rp_inc = (tx_rp_r == TX_TOP) ? '0 : tx_rp_r + 1'b1;

  // bytes buffered in receive ring, clipped to the count asked for
  always_comb begin
    diff = {1'b0, rx_wp_r} - {1'b0, rx_rp_r};
    if (rx_wp_r < rx_rp_r) begin
      diff = diff + RX_SPAN;
    end
    avail   = diff[RPW-1:0];
    avail_w = CNT_W'(avail);
    n_w     = (avail_w < cnt_r) ? avail_w : cnt_r;
    n_rd    = RPW'(n_w);
  end

  assign rx_rd_addr = cmd.rd_send ? rx_rp_inc : rx_rp_r;
  assign slot_free  = !out_valid_r || out_ready;

  assign sts.func      = func_r;
  assign sts.tx_empty  = (tx_wp_r == tx_rp_r);
  assign sts.tx_full   = (tx_wp_inc == tx_rp_r);
  assign sts.line_free = line_free_r;
  assign sts.rd_zero   = (n_w == '0);
  assign sts.rd_last   = (rem_r == RPW'(1));
  assign sts.slot_free = slot_free;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_r <= in_func;
      byte_r <= in_byte;
      cnt_r  <= in_read_count;
    end
    if (cmd.rd_start) begin
      rem_r <= n_rd;
    end else if (cmd.rd_send) begin
      rem_r <= rem_r - 1'b1;
    end
  end

  // receive ring storage
  always_ff @(posedge clk) begin
    if (cmd.rx_push) begin
      rx_mem[rx_wp_r] <= byte_r;
    end
    if (cmd.rd_start || cmd.rd_send) begin
      rx_q_r <= rx_mem[rx_rd_addr];
    end
  end

  // transmit ring storage
  always_ff @(posedge clk) begin
    if (cmd.tx_push) begin
      tx_mem[tx_wp_r] <= byte_r;
    end
    if (cmd.tx_fetch) begin
      tx_q_r <= tx_mem[tx_rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wp_r     <= '0;
      rx_rp_r     <= '0;
      tx_wp_r     <= '0;
      tx_rp_r     <= '0;
      line_free_r <= 1'b1;
    end else begin
      if (cmd.rx_push) begin
        rx_wp_r <= rx_wp_inc;
        // full ring: oldest byte dropped
        if (rx_wp_inc == rx_rp_r) begin
          rx_rp_r <= rx_rp_inc;
        end
      end
      if (cmd.rd_send) begin
        rx_rp_r <= rx_rp_inc;
      end
      if (cmd.tx_push) begin
        tx_wp_r <= tx_wp_inc;
      end
      if (cmd.tx_send) begin
        tx_rp_r <= tx_rp_inc;
      end
      if (cmd.tx_send || cmd.tx_direct) begin
        line_free_r <= 1'b0;
      end else if (cmd.line_rel) begin
        line_free_r <= 1'b1;
      end
    end
  end

  assign emit = cmd.rx_push | cmd.line_rel | cmd.tx_direct | cmd.tx_refuse |
                cmd.tx_push | cmd.tx_send | cmd.rd_none | cmd.rd_send;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_lv_r   <= cmd.tx_direct | cmd.tx_send;
      out_lb_r   <= cmd.tx_direct ? byte_r : (cmd.tx_send ? tx_q_r : '0);
      out_acc_r  <= cmd.tx_direct | cmd.tx_push;
      out_rv_r   <= cmd.rd_send;
      out_rb_r   <= cmd.rd_send ? rx_q_r : '0;
      out_last_r <= cmd.rd_send ? sts.rd_last : 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_valid   = out_lv_r;
  assign out_line_byte    = out_lb_r;
  assign out_enq_accepted = out_acc_r;
  assign out_read_valid   = out_rv_r;
  assign out_read_byte    = out_rb_r;
  assign out_last         = out_last_r;

endmodule

FILE: rtl/core/serial_rx_tx_ring_buffers_top.sv
// top level of the serial port receive and transmit ring buffers
// Buffers one serial port in a receive ring and a transmit ring, each holding
// up to depth minus one bytes in a single-port-style memory with a registered
// read. Items are taken one at a time: the block accepts an item in its idle
// cycle and executes it in the next. A received line byte, an enqueue and an
// empty line-ready pass through the idle and execute states; a line-ready that
// passes on a queued byte reads it from the transmit memory in the execute
// state and hands it to the line from the transmit send state. A software read
// first fetches the first byte from the receive memory, then delivers one byte
// per cycle while the result slot is free, with the next read issued at the
// advanced pointer. A result waits in the output register while the
// controller carries on; when the controller has its next result ready and
// the previous one is still held, it stalls while out_ready stays low. When
// the receive ring is full a new line byte overwrites the oldest. An enqueue
// into a full transmit ring is refused with enq_accepted low. Store contents
// are not cleared at reset; pointers are, so no unwritten entry is ever read.
module serial_rx_tx_ring_buffers_top #(
  parameter int RX_DEPTH = srb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = srb_pkg::TX_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input item channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [srb_pkg::FUNC_W-1:0]  in_func,
  input  logic [srb_pkg::BYTE_W-1:0]  in_byte,
  input  logic [srb_pkg::CNT_W-1:0]   in_read_count,
  // result item channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_line_valid,
  output logic [srb_pkg::BYTE_W-1:0]  out_line_byte,
  output logic                        out_enq_accepted,
  output logic                        out_read_valid,
  output logic [srb_pkg::BYTE_W-1:0]  out_read_byte,
  output logic                        out_last
);
  import srb_pkg::*;

  srb_cmd_t cmd;   // controller commands
  srb_sts_t sts;   // datapath status

  // sequencer: idle, execute, transmit send, read drain
  srb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // rings, pointers, line state and result register
  srb_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_func),
    .in_byte          (in_byte),
    .in_read_count    (in_read_count),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_valid   (out_line_valid),
    .out_line_byte    (out_line_byte),
    .out_enq_accepted (out_enq_accepted),
    .out_read_valid   (out_read_valid),
    .out_read_byte    (out_read_byte),
    .out_last         (out_last)
  );

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous one still executing");

  // a result is either a line byte or a read byte, never both
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_line_valid && out_read_valid))
    else $error("result carries both line and read byte");

  // only software reads give more than one result per item
  a_multi_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_read_valid)
    else $error("non-final result that is not a read byte");

  // a read result never carries the enqueue flag
  a_enq_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |-> !out_enq_accepted)
    else $error("read result flagged as accepted enqueue");

endmodule

FILE: sim/tb.sv
// testbench for the serial port receive and transmit ring buffers
`timescale 1ns / 100ps

module tb;
  import srb_pkg::*;

  localparam int RXD         = RX_DEPTH_DEF;
  localparam int TXD         = TX_DEPTH_DEF;
  localparam int RIW         = $clog2(RXD);
  localparam int TIW         = $clog2(TXD);
  localparam int ITEM_TARGET = 370;
  // the worst case (every read at 31 bytes, every byte stalled for the longest
  // gap) stays well below this limit, so this leaves a wide margin
  localparam int CYCLE_LIMIT = 1_500_000;

  // one result item, fields in port order
  typedef struct packed {
    logic       line_valid;
    logic [7:0] line_byte;
    logic       enq_accepted;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       last;
  } srb_result_t;

  // one row of the directed table; when typed is set, want is the result
  // pushed instead of the predicted one
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [7:0]        data;
    logic [7:0]        count;
    logic              typed;
    srb_result_t       want;
  } stim_row_t;

  // nothing sent, nothing read, just the closing marker
  localparam srb_result_t RES_QUIET  = '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1};
  // enqueue taken into the ring, line still busy
  localparam srb_result_t RES_QUEUED = '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1};

  localparam int DIR_ROWS_N = 24;
  localparam stim_row_t DIR_ROWS [DIR_ROWS_N] = '{
    // read right after reset: nothing buffered
    '{FN_READ,     8'h00, 8'd5,   1'b1, RES_QUIET},
    // line ready with nothing queued, line stays free
    '{FN_LINE_RDY, 8'h00, 8'd0,   1'b1, RES_QUIET},
    // empty ring and free line: byte goes straight out
    '{FN_ENQ,      8'hA5, 8'd0,   1'b1, '{1'b1, 8'hA5, 1'b1, 1'b0, 8'h00, 1'b1}},
    // line now busy, so these two queue
    '{FN_ENQ,      8'h00, 8'd0,   1'b1, RES_QUEUED},
    '{FN_ENQ,      8'hFF, 8'd0,   1'b1, RES_QUEUED},
    // line ready passes the queued bytes on, oldest first
    '{FN_LINE_RDY, 8'h00, 8'd0,   1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1}},
    '{FN_LINE_RDY, 8'h00, 8'd0,   1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b1}},
    // ring drained: line goes free
    '{FN_LINE_RDY, 8'h00, 8'd0,   1'b1, RES_QUIET},
    '{FN_ENQ,      8'h3C, 8'd0,   1'b1, '{1'b1, 8'h3C, 1'b1, 1'b0, 8'h00, 1'b1}},
    '{FN_LINE_RDY, 8'h00, 8'd0,   1'b1, RES_QUIET},
    // line bytes at the extremes
    '{FN_RX_BYTE,  8'h00, 8'd0,   1'b1, RES_QUIET},
    '{FN_RX_BYTE,  8'hFF, 8'd0,   1'b1, RES_QUIET},
    '{FN_RX_BYTE,  8'h81, 8'd0,   1'b1, RES_QUIET},
    // zero count read gives the empty result even with bytes buffered
    '{FN_READ,     8'h00, 8'd0,   1'b1, RES_QUIET},
    '{FN_READ,     8'h00, 8'd1,   1'b0, RES_QUIET},
    // asking more than present returns only what is there
    '{FN_READ,     8'h00, 8'd255, 1'b0, RES_QUIET},
    '{FN_READ,     8'h00, 8'd255, 1'b1, RES_QUIET},
    '{FN_RX_BYTE,  8'h11, 8'd0,   1'b1, RES_QUIET},
    '{FN_RX_BYTE,  8'h22, 8'd0,   1'b1, RES_QUIET},
    '{FN_RX_BYTE,  8'h44, 8'd0,   1'b1, RES_QUIET},
    '{FN_RX_BYTE,  8'h88, 8'd0,   1'b1, RES_QUIET},
    '{FN_READ,     8'h00, 8'd2,   1'b0, RES_QUIET},
    '{FN_READ,     8'h00, 8'h80,  1'b0, RES_QUIET},
    '{FN_ENQ,      8'h5A, 8'd0,   1'b1, '{1'b1, 8'h5A, 1'b1, 1'b0, 8'h00, 1'b1}}
  };

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func       = FN_RX_BYTE;
  logic [BYTE_W-1:0]   in_byte       = '0;
  logic [CNT_W-1:0]    in_read_count = '0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic                out_line_valid;
  logic [BYTE_W-1:0]   out_line_byte;
  logic                out_enq_accepted;
  logic                out_read_valid;
  logic [BYTE_W-1:0]   out_read_byte;
  logic                out_last;

  // predictor state: both rings, their pointers and the line flag
  logic [7:0] rx_mem [RXD];
  logic [7:0] tx_mem [TXD];
  int         rx_wp, rx_rp, tx_wp, tx_rp;
  bit         line_idle;

  srb_result_t ring_results [$];   // results still due, oldest first

  bit  quiet;                      // stretch with no idling on either side
  int  error_count     = 0;
  int  results_checked = 0;
  int  items_sent      = 0;
  int  func_seen [4];
  int  tx_refused      = 0;
  int  rx_dropped      = 0;
  int  cycle_count     = 0;
  int  stall_left      = 0;

  serial_rx_tx_ring_buffers_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_byte          (in_byte),
    .in_read_count    (in_read_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_valid   (out_line_valid),
    .out_line_byte    (out_line_byte),
    .out_enq_accepted (out_enq_accepted),
    .out_read_valid   (out_read_valid),
    .out_read_byte    (out_read_byte),
    .out_last         (out_last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idle length: mostly none, often a few cycles, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // advance the ring predictor by one item and queue the results it causes;
  // a typed row replaces the single predicted result with the table entry
  function automatic void ring_step(input logic [FUNC_W-1:0] f, input logic [7:0] d,
                                    input logic [7:0] c, input bit typed,
                                    input srb_result_t want);
    srb_result_t r;
    int          avail;
    int          n;
    bit          multi;
    r      = '0;
    r.last = 1'b1;
    multi  = 1'b0;
    case (f)
      FN_RX_BYTE: begin
        rx_mem[RIW'(rx_wp)] = d;
        rx_wp = (rx_wp + 1) % RXD;
        // ring full: the oldest byte goes
        if (rx_wp == rx_rp) begin
          rx_rp = (rx_rp + 1) % RXD;
          rx_dropped++;
        end
      end
      FN_LINE_RDY: begin
        if (tx_wp != tx_rp) begin
          r.line_valid = 1'b1;
          r.line_byte  = tx_mem[TIW'(tx_rp)];
          tx_rp        = (tx_rp + 1) % TXD;
          line_idle    = 1'b0;
        end else begin
          line_idle = 1'b1;
        end
      end
      FN_ENQ: begin
        if (tx_wp == tx_rp && line_idle) begin
          line_idle      = 1'b0;
          r.line_valid   = 1'b1;
          r.line_byte    = d;
          r.enq_accepted = 1'b1;
        end else if ((tx_wp + 1) % TXD == tx_rp) begin
          tx_refused++;
        end else begin
          tx_mem[TIW'(tx_wp)] = d;
          tx_wp          = (tx_wp + 1) % TXD;
          r.enq_accepted = 1'b1;
        end
      end
      default: begin
        avail = (RXD + rx_wp - rx_rp) % RXD;
        n     = (avail < int'(c)) ? avail : int'(c);
        for (int i = 0; i < n; i++) begin
          r.read_valid = 1'b1;
          r.read_byte  = rx_mem[RIW'(rx_rp)];
          r.last       = (i == n - 1);
          rx_rp        = (rx_rp + 1) % RXD;
          ring_results.push_back(r);
          multi = 1'b1;
        end
      end
    endcase
    if (!multi) ring_results.push_back(typed ? want : r);
  endfunction

  // present one item after a random gap and hold it until it is taken;
  // the prediction is made up front since the payload cannot change
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [7:0] d,
                           input logic [7:0] c, input bit typed,
                           input srb_result_t want);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ring_step(f, d, c, typed, want);
    in_valid      <= 1'b1;
    in_func       <= f;
    in_byte       <= d;
    in_read_count <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    func_seen[f]++;
    items_sent++;
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
             results_checked, field, got, want);
    error_count++;
  endtask

  // result side back-pressure: random stalls, none during quiet stretches
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= quiet ? 0 : pick_gap();
    end
  end

  // compare each taken result with the oldest one still due
  always @(posedge clk) begin : result_check
    srb_result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (ring_results.size() == 0) begin
        $display("unexpected result: line %0b/%0h enq %0b read %0b/%0h last %0b",
                 out_line_valid, out_line_byte, out_enq_accepted,
                 out_read_valid, out_read_byte, out_last);
        error_count++;
      end else begin
        due = ring_results.pop_front();
        if (out_line_valid !== due.line_valid)
          report_mismatch("line_valid", int'(out_line_valid), int'(due.line_valid));
        if (out_line_byte !== due.line_byte)
          report_mismatch("line_byte", int'(out_line_byte), int'(due.line_byte));
        if (out_enq_accepted !== due.enq_accepted)
          report_mismatch("enq_accepted", int'(out_enq_accepted),
                          int'(due.enq_accepted));
        if (out_read_valid !== due.read_valid)
          report_mismatch("read_valid", int'(out_read_valid), int'(due.read_valid));
        if (out_read_byte !== due.read_byte)
          report_mismatch("read_byte", int'(out_read_byte), int'(due.read_byte));
        if (out_last !== due.last)
          report_mismatch("last", int'(out_last), int'(due.last));
      end
      results_checked++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, ring_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          mode;
    int          n;
    int          r;
    logic [7:0]  cnt;
    rx_wp     = 0;
    rx_rp     = 0;
    tx_wp     = 0;
    tx_rp     = 0;
    line_idle = 1'b1;
    quiet     = 1'b0;
    foreach (func_seen[i]) func_seen[i] = 0;

    // reset held at the start, once
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS_N; i++)
      send_item(DIR_ROWS[i].func, DIR_ROWS[i].data, DIR_ROWS[i].count,
                DIR_ROWS[i].typed, DIR_ROWS[i].want);

    // random bursts: ring fills past full, drains, transmit floods that hit
    // the refusal, line-ready runs, and plain noise between them
    while (items_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 4) == 0);
      mode  = $urandom_range(0, 9);
      if (mode < 2) begin
        n = $urandom_range(1, 40);
        repeat (n) send_item(FN_RX_BYTE, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 1'b0, RES_QUIET);
      end else if (mode < 4) begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          r = $urandom_range(0, 9);
          if (r < 6)      cnt = 8'($urandom_range(0, 12));
          else if (r < 8) cnt = 8'($urandom_range(13, 40));
          else            cnt = 8'($urandom_range(0, 255));
          send_item(FN_READ, 8'($urandom_range(0, 255)), cnt, 1'b0, RES_QUIET);
        end
      end else if (mode < 6) begin
        n = $urandom_range(1, 36);
        repeat (n) send_item(FN_ENQ, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 1'b0, RES_QUIET);
      end else if (mode < 8) begin
        n = $urandom_range(1, 10);
        repeat (n) send_item(FN_LINE_RDY, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 1'b0, RES_QUIET);
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) send_item(FUNC_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 1'b0, RES_QUIET);
      end
    end
    in_valid <= 1'b0;

    // let every due result come back, then watch a while for strays
    while (ring_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d items (line byte %0d, line ready %0d, enqueue %0d, read %0d)",
             items_sent, func_seen[FN_RX_BYTE], func_seen[FN_LINE_RDY],
             func_seen[FN_ENQ], func_seen[FN_READ]);
    $display("%0d results checked, %0d enqueues refused on a full ring, %0d bytes dropped",
             results_checked, tx_refused, rx_dropped);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/srb_pkg.sv
rtl/core/srb_ctrl.sv
rtl/core/srb_dp.sv
rtl/core/serial_rx_tx_ring_buffers_top.sv
sim/tb.sv
